FILE: hw/rtl/spdf_pkg.sv
package spdf_pkg;

    localparam int unsigned CfgIdxW = 2;

    typedef enum logic [CfgIdxW-1:0] {
        REG_SYNC_WORD = 2'd0,
        REG_MARKER    = 2'd1,
        REG_TRIG_LEN  = 2'd2
    } t_reg_idx;

    localparam logic [31:0] SyncReset   = 32'he2250813;
    localparam logic [15:0] MarkerReset = 16'heb90;
    localparam logic [7:0]  TrigReset   = 8'd10;
    localparam logic [7:0]  TrigMask    = 8'h3c;
    localparam logic [7:0]  TrigValue   = 8'h30;
    localparam logic [13:0] IdMask      = 14'h3fff;

    typedef enum logic [2:0] {
        ROLE_HUNT    = 3'd0,
        ROLE_HEADER  = 3'd1,
        ROLE_TRIGGER = 3'd2,
        ROLE_FRONT   = 3'd3,
        ROLE_TIME    = 3'd4
    } t_role;

    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_PKTLEN = 2'd1,
        ERR_SUBLEN = 2'd2,
        ERR_MARKER = 2'd3
    } t_err;

    // One tagged word as it leaves the parser. Packed width is 38 bits.
    typedef struct packed {
        logic [7:0]  out_byte;
        t_role       byte_role;
        logic [13:0] packet_id;
        logic [7:0]  frontend_id;
        logic        subframe_end;
        logic        packet_end;
        logic        sequence_warning;
        t_err        error_code;
    } t_tag;

    typedef struct packed {
        logic [31:0] sync_word;
        logic [15:0] marker;
        logic [7:0]  trig_len;
    } t_cfg;

endpackage

FILE: hw/rtl/spdf_parser.sv
module spdf_parser (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  spdf_pkg::t_cfg i_cfg,
    input  logic           i_valid,
    input  logic [7:0]     i_byte,
    output logic           o_ready,
    output logic           o_valid,
    output spdf_pkg::t_tag o_tag,
    input  logic           i_ready
);
    import spdf_pkg::*;

    typedef enum logic [3:0] {
        PH_HUNT, PH_HDR, PH_MARK, PH_MARK_FE, PH_FLAG,
        PH_TRIG, PH_FELEN, PH_FEDATA, PH_SKIP, PH_SYNC
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [31:0] r_hist;
    logic [3:0]  r_cnt, n_cnt;
    logic [15:0] r_body, n_body;
    logic [15:0] r_sub, n_sub;
    logic [13:0] r_pid, n_pid;
    logic [13:0] r_prev, n_prev;
    logic        r_prev_ok, n_prev_ok;
    logic [7:0]  r_fid, n_fid;
    logic        r_valid;
    t_tag        r_tag, n_tag;

    logic [31:0] hist;
    logic [15:0] half;
    logic [13:0] id_dec;
    logic [7:0]  trig_eff;
    logic        take;
    t_role       role;
    t_err        err;
    logic        sfend, pend, warn;

    assign o_ready = !r_valid || i_ready;
    assign take    = i_valid && o_ready;
    assign hist    = {r_hist[23:0], i_byte};
    assign half    = hist[15:0];
    assign id_dec  = (half[13:0] - 14'd1) & IdMask;
    assign trig_eff = (i_cfg.trig_len < 8'd2) ? 8'd2 : i_cfg.trig_len;

    always_comb begin
        n_phase = r_phase; n_cnt = r_cnt; n_body = r_body; n_sub = r_sub;
        n_pid = r_pid; n_prev = r_prev; n_prev_ok = r_prev_ok; n_fid = r_fid;
        role = ROLE_HUNT; err = ERR_NONE; sfend = 1'b0; pend = 1'b0; warn = 1'b0;
        if (r_phase == PH_MARK || r_phase == PH_MARK_FE || r_phase == PH_FLAG ||
            r_phase == PH_TRIG || r_phase == PH_FELEN || r_phase == PH_FEDATA ||
            r_phase == PH_SKIP) begin
            if (r_body == 16'd0) begin
                if (((r_phase == PH_MARK || r_phase == PH_MARK_FE) && r_cnt == 4'd0)
                    || r_phase == PH_SKIP) begin
                    n_phase = PH_SYNC;
                    n_cnt   = 4'd0;
                end else begin
                    err = (r_phase == PH_MARK || r_phase == PH_MARK_FE) ?
                          ERR_MARKER : ERR_SUBLEN;
                    n_phase = PH_HUNT;
                end
            end else begin
                n_body = r_body - 16'd1;
            end
        end
        if (err == ERR_NONE) begin
            unique case (n_phase)
                PH_HUNT: begin
                    if (hist == i_cfg.sync_word) begin
                        n_phase = PH_HDR;
                        n_cnt   = 4'd0;
                    end
                end
                PH_HDR: begin
                    role = (r_cnt < 4'd4) ? ROLE_HEADER : ROLE_TIME;
                    if (r_cnt == 4'd1) begin
                        if (r_prev_ok && ((id_dec & r_prev) != r_prev)) warn = 1'b1;
                        n_pid = half[13:0];
                        n_prev = half[13:0];
                        n_prev_ok = 1'b1;
                    end
                    if (r_cnt == 4'd3 && half < 16'd7) begin
                        err = ERR_PKTLEN;
                        n_phase = PH_HUNT;
                    end else begin
                        if (r_cnt == 4'd3) n_body = half - 16'd7;
                        if (r_cnt >= 4'd11) begin
                            n_phase = PH_MARK;
                            n_cnt = 4'd0;
                        end else begin
                            n_cnt = r_cnt + 4'd1;
                        end
                    end
                end
                PH_MARK, PH_MARK_FE: begin
                    if (n_cnt == 4'd0) begin
                        n_cnt = 4'd1;
                    end else if (half == i_cfg.marker) begin
                        n_phase = PH_FLAG;
                        n_cnt = 4'd0;
                    end else if (half == i_cfg.sync_word[31:16]) begin
                        n_phase = PH_SKIP;
                    end else begin
                        err = (n_phase == PH_MARK) ? ERR_MARKER : ERR_SUBLEN;
                        n_phase = PH_HUNT;
                    end
                end
                PH_FLAG: begin
                    role = ROLE_FRONT;
                    if (r_cnt == 4'd0) begin
                        n_cnt = 4'd1;
                    end else begin
                        n_fid = i_byte;
                        n_cnt = 4'd0;
                        if ((i_byte & TrigMask) == TrigValue) begin
                            role = ROLE_TRIGGER;
                            if (trig_eff == 8'd2) begin
                                sfend = 1'b1;
                                n_phase = PH_MARK;
                            end else begin
                                n_sub = {8'd0, trig_eff - 8'd2};
                                n_phase = PH_TRIG;
                            end
                        end else begin
                            n_phase = PH_FELEN;
                        end
                    end
                end
                PH_TRIG, PH_FEDATA: begin
                    role = (n_phase == PH_TRIG) ? ROLE_TRIGGER : ROLE_FRONT;
                    if (r_sub <= 16'd1) begin
                        n_sub = 16'd0;
                        sfend = 1'b1;
                        n_phase = (r_phase == PH_TRIG) ? PH_MARK : PH_MARK_FE;
                        n_cnt = 4'd0;
                    end else begin
                        n_sub = r_sub - 16'd1;
                    end
                end
                PH_FELEN: begin
                    role = ROLE_FRONT;
                    if (r_cnt == 4'd0) begin
                        n_cnt = 4'd1;
                    end else if (half < 16'd2) begin
                        err = ERR_SUBLEN;
                        n_phase = PH_HUNT;
                    end else if (half == 16'd2) begin
                        sfend = 1'b1;
                        n_phase = PH_MARK_FE;
                        n_cnt = 4'd0;
                    end else begin
                        n_sub = half - 16'd2;
                        n_phase = PH_FEDATA;
                    end
                end
                PH_SKIP: begin
                end
                PH_SYNC: begin
                    if (n_cnt < 4'd3) begin
                        n_cnt = n_cnt + 4'd1;
                    end else if (hist == i_cfg.sync_word) begin
                        pend = 1'b1;
                        n_phase = PH_HDR;
                        n_cnt = 4'd0;
                    end else begin
                        err = ERR_PKTLEN;
                        n_phase = PH_HUNT;
                    end
                end
                default: n_phase = PH_HUNT;
            endcase
        end
        if (err != ERR_NONE) role = ROLE_HUNT;
        n_tag = '{out_byte: i_byte, byte_role: role, packet_id: n_pid,
                  frontend_id: n_fid, subframe_end: sfend, packet_end: pend,
                  sequence_warning: warn, error_code: err};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT; r_hist <= '0; r_cnt <= '0; r_body <= '0;
            r_sub <= '0; r_pid <= '0; r_prev <= '0; r_prev_ok <= 1'b0;
            r_fid <= '0; r_valid <= 1'b0;
        end else begin
            if (take) begin
                r_phase <= n_phase; r_hist <= hist; r_cnt <= n_cnt; r_body <= n_body;
                r_sub <= n_sub; r_pid <= n_pid; r_prev <= n_prev;
                r_prev_ok <= n_prev_ok; r_fid <= n_fid;
            end
            if (take) r_valid <= 1'b1;
            else if (i_ready) r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) r_tag <= n_tag;
    end

    assign o_valid = r_valid;
    assign o_tag   = r_tag;

`ifndef NO_ASSERTIONS
    a_err_hunts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && err != ERR_NONE |=> r_phase == PH_HUNT)
        else $error("error did not return parser to hunting");
    a_err_role: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_tag.error_code != ERR_NONE |-> r_tag.byte_role == ROLE_HUNT)
        else $error("error word carries a role");
    a_pend_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && pend |=> r_phase == PH_HDR)
        else $error("packet end without header phase");
`endif
endmodule

FILE: hw/rtl/spdf_outq.sv
module spdf_outq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  spdf_pkg::t_tag i_tag,
    output logic           o_ready,
    output logic           o_valid,
    output spdf_pkg::t_tag o_tag,
    input  logic           i_ready
);
    import spdf_pkg::*;

    t_tag       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_ready = r_cnt != 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_tag   = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= !r_wp;
            if (pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_tag;
    end

`ifndef NO_ASSERTIONS
    a_no_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd2 |-> !push)
        else $error("queue overflow");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !pop |=> r_cnt == $past(r_cnt) + 2'd1)
        else $error("queue count slip");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("queue count out of range");
`endif
endmodule

FILE: hw/rtl/science_packet_deframer_top.sv
// Channel   Dir  Payload                                        Handshake
// s_axis    in   tdata[7:0] in_byte                             s_axis_tvalid/tready
// m_axis    out  tdata[31:0] tagged byte, tuser[6:0] tags, tlast m_axis_tvalid/tready
// cfg       in   i_cfg_index[1:0], i_cfg_data[31:0]              i_cfg_valid/o_cfg_ready
//
// One word is accepted every cycle while the master side keeps up. An accepted word is
// tagged into the parser's output register and then moves into the queue, from which
// the master side can take it.
// Reset is synchronous and active low; it restores the default registers.
// A stall downstream fills the two-entry queue, then the parser's output
// register, and only then drops s_axis_tready.
module science_packet_deframer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] out_byte, [21:8] packet_id, [29:22] frontend_id, [31:30] zero
    output logic [31:0] m_axis_tdata,
    // [2:0] byte_role, [3] packet_end, [4] sequence_warning, [6:5] error_code
    output logic [6:0]  m_axis_tuser,
    // High on the last byte of a sub-frame.
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import spdf_pkg::*;

    t_cfg r_cfg;
    logic p_valid, p_ready;
    t_tag p_tag, q_tag;

    // Writable always; the user must write only while the block is idle (unenforced).
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{sync_word: SyncReset, marker: MarkerReset, trig_len: TrigReset};
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_SYNC_WORD: r_cfg.sync_word <= i_cfg_data;
                REG_MARKER:    r_cfg.marker    <= i_cfg_data[15:0];
                REG_TRIG_LEN:  r_cfg.trig_len  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Front: parse and tag each byte.
    spdf_parser u_parser (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg),
        .i_valid(s_axis_tvalid), .i_byte(s_axis_tdata), .o_ready(s_axis_tready),
        .o_valid(p_valid), .o_tag(p_tag), .i_ready(p_ready)
    );

    // Back: a short queue toward the master side.
    spdf_outq u_outq (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(p_valid), .i_tag(p_tag), .o_ready(p_ready),
        .o_valid(m_axis_tvalid), .o_tag(q_tag), .i_ready(m_axis_tready)
    );

    assign m_axis_tdata = {2'd0, q_tag.frontend_id, q_tag.packet_id, q_tag.out_byte};
    assign m_axis_tuser = {q_tag.error_code, q_tag.sequence_warning,
                           q_tag.packet_end, q_tag.byte_role};
    assign m_axis_tlast = q_tag.subframe_end;

`ifndef NO_ASSERTIONS
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tdata[31:30] == 2'd0)
        else $error("tdata padding not zero");
    a_err_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[6:5] != 2'd0 |-> m_axis_tuser[3] == 1'b0)
        else $error("error and packet end together");
    a_role_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser[2:0] <= 3'd4)
        else $error("role out of range");
`endif
endmodule

FILE: dv/science_packet_deframer_top_tb.sv
module science_packet_deframer_top_tb;

    import spdf_pkg::*;

    // Parse phases of the deframer, mirrored by the byte-tag predictor.
    typedef enum logic [3:0] {
        PH_HUNT, PH_HDR, PH_MARK, PH_MARK_FE, PH_FLAG,
        PH_TRIG, PH_FELEN, PH_FEDATA, PH_SKIP, PH_SYNC
    } t_phase;

    // Shapes of generated packets; all but PK_MIXED steer the parser into a special path.
    typedef enum int {
        PK_MIXED, PK_EMPTY, PK_SHORT_LEN, PK_SYNC_HALF, PK_BAD_MARKER,
        PK_FE_TOO_SHORT, PK_FE_MIN, PK_TRIG_ONLY, PK_CUT_BODY
    } t_pkt_kind;

    // Predicts the tag of every byte and checks the tagged words that come out.
    class deframer_scoreboard;
        t_tag        tag_q[$];
        int          errors;
        int          n_checked, n_pkt_end, n_err_words, n_warn;
        logic [31:0] sync_word;
        logic [15:0] marker;
        logic [7:0]  trig_len;
        logic [31:0] history;
        t_phase      phase;
        logic [15:0] fld_cnt, body_left, sub_left;
        logic [13:0] cur_id, prev_id;
        logic        prev_valid;
        logic [7:0]  cur_fe;

        function new();
            sync_word = SyncReset;
            marker    = MarkerReset;
            trig_len  = TrigReset;
            history   = '0;
            phase     = PH_HUNT;
            fld_cnt   = '0;
            body_left = '0;
            sub_left  = '0;
            cur_id    = '0;
            prev_id   = '0;
            prev_valid = 1'b0;
            cur_fe    = '0;
            errors    = 0;
            n_checked = 0;
            n_pkt_end = 0;
            n_err_words = 0;
            n_warn    = 0;
        endfunction

        function void set_reg(t_reg_idx idx, logic [31:0] val);
            case (idx)
                REG_SYNC_WORD: sync_word = val;
                REG_MARKER:    marker = val[15:0];
                REG_TRIG_LEN:  trig_len = val[7:0];
                default: ;
            endcase
        endfunction

        // Advance the parser by one accepted byte and queue the tag it must get.
        function void note_byte(logic [7:0] b);
            t_tag        t;
            logic [15:0] half;
            logic [13:0] dec;
            logic [7:0]  tl;
            logic [2:0]  role;
            logic [1:0]  err;
            logic        sfend, pend, warn;
            role = '0; err = '0; sfend = 0; pend = 0; warn = 0;
            history = {history[23:0], b};
            half = history[15:0];

            // The body budget is spent before the byte is parsed; running out
            // either hands over to the sync check or breaks an open field.
            if (phase >= PH_MARK && phase <= PH_SKIP) begin
                if (body_left == 0) begin
                    if (((phase == PH_MARK || phase == PH_MARK_FE) && fld_cnt == 0)
                        || phase == PH_SKIP) begin
                        phase = PH_SYNC;
                        fld_cnt = 0;
                    end else begin
                        err = (phase <= PH_MARK_FE) ? ERR_MARKER : ERR_SUBLEN;
                        phase = PH_HUNT;
                    end
                end else begin
                    body_left--;
                end
            end

            if (err == ERR_NONE) begin
                case (phase)
                    PH_HUNT: begin
                        if (history == sync_word) begin
                            phase = PH_HDR;
                            fld_cnt = 0;
                        end
                    end
                    PH_HDR: begin
                        role = (fld_cnt < 4) ? ROLE_HEADER : ROLE_TIME;
                        if (fld_cnt == 1) begin
                            dec = half[13:0] - 14'd1;
                            if (prev_valid && ((dec & prev_id) != prev_id)) warn = 1;
                            cur_id = half[13:0];
                            prev_id = half[13:0];
                            prev_valid = 1;
                        end else if (fld_cnt == 3) begin
                            if (half < 7) begin
                                err = ERR_PKTLEN;
                                phase = PH_HUNT;
                            end else begin
                                body_left = half - 16'd7;
                            end
                        end
                        if (err == ERR_NONE) begin
                            if (fld_cnt >= 11) begin
                                phase = PH_MARK;
                                fld_cnt = 0;
                            end else begin
                                fld_cnt++;
                            end
                        end
                    end
                    PH_MARK, PH_MARK_FE: begin
                        if (fld_cnt == 0) begin
                            fld_cnt = 1;
                        end else if (half == marker) begin
                            phase = PH_FLAG;
                            fld_cnt = 0;
                        end else if (half == sync_word[31:16]) begin
                            phase = PH_SKIP;
                        end else begin
                            err = (phase == PH_MARK) ? ERR_MARKER : ERR_SUBLEN;
                            phase = PH_HUNT;
                        end
                    end
                    PH_FLAG: begin
                        if (fld_cnt == 0) begin
                            // The flag byte comes before the id, so its kind is unknown.
                            role = ROLE_FRONT;
                            fld_cnt = 1;
                        end else begin
                            cur_fe = b;
                            fld_cnt = 0;
                            if ((b & TrigMask) == TrigValue) begin
                                tl = (trig_len < 2) ? 8'd2 : trig_len;
                                role = ROLE_TRIGGER;
                                if (tl == 2) begin
                                    sfend = 1;
                                    phase = PH_MARK;
                                end else begin
                                    sub_left = {8'd0, tl - 8'd2};
                                    phase = PH_TRIG;
                                end
                            end else begin
                                role = ROLE_FRONT;
                                phase = PH_FELEN;
                            end
                        end
                    end
                    PH_TRIG, PH_FEDATA: begin
                        role = (phase == PH_TRIG) ? ROLE_TRIGGER : ROLE_FRONT;
                        if (sub_left <= 1) begin
                            sub_left = 0;
                            sfend = 1;
                            phase = (phase == PH_TRIG) ? PH_MARK : PH_MARK_FE;
                            fld_cnt = 0;
                        end else begin
                            sub_left--;
                        end
                    end
                    PH_FELEN: begin
                        role = ROLE_FRONT;
                        if (fld_cnt == 0) begin
                            fld_cnt = 1;
                        end else if (half < 2) begin
                            err = ERR_SUBLEN;
                            phase = PH_HUNT;
                        end else if (half == 2) begin
                            sfend = 1;
                            phase = PH_MARK_FE;
                            fld_cnt = 0;
                        end else begin
                            sub_left = half - 16'd2;
                            phase = PH_FEDATA;
                        end
                    end
                    PH_SKIP: ;
                    PH_SYNC: begin
                        if (fld_cnt < 3) begin
                            fld_cnt++;
                        end else if (history == sync_word) begin
                            pend = 1;
                            phase = PH_HDR;
                            fld_cnt = 0;
                        end else begin
                            err = ERR_PKTLEN;
                            phase = PH_HUNT;
                        end
                    end
                    default: phase = PH_HUNT;
                endcase
            end

            if (err != ERR_NONE) role = ROLE_HUNT;
            t.out_byte = b;
            t.byte_role = t_role'(role);
            t.packet_id = cur_id;
            t.frontend_id = cur_fe;
            t.subframe_end = sfend;
            t.packet_end = pend;
            t.sequence_warning = warn;
            t.error_code = t_err'(err);
            tag_q = {tag_q, t};
        endfunction

        // Compare one output word, field by field, with the oldest prediction.
        function void check_word(logic [31:0] d, logic [6:0] u, logic l);
            t_tag e;
            if (tag_q.size() == 0) begin
                $display("%0t: unexpected output word, actual data %h user %h last %b",
                         $time, d, u, l);
                errors++;
                return;
            end
            e = tag_q.pop_front();
            n_checked++;
            if (e.packet_end) n_pkt_end++;
            if (e.error_code != ERR_NONE) n_err_words++;
            if (e.sequence_warning) n_warn++;
            if (d[7:0] !== e.out_byte) begin
                $display("%0t: out_byte expected %h actual %h", $time, e.out_byte, d[7:0]);
                errors++;
            end
            if (u[2:0] !== e.byte_role) begin
                $display("%0t: byte_role expected %0d actual %0d", $time, e.byte_role, u[2:0]);
                errors++;
            end
            if (d[21:8] !== e.packet_id) begin
                $display("%0t: packet_id expected %h actual %h", $time, e.packet_id, d[21:8]);
                errors++;
            end
            if (d[29:22] !== e.frontend_id) begin
                $display("%0t: frontend_id expected %h actual %h", $time,
                         e.frontend_id, d[29:22]);
                errors++;
            end
            if (d[31:30] !== 2'd0) begin
                $display("%0t: tdata pad expected 0 actual %h", $time, d[31:30]);
                errors++;
            end
            if (l !== e.subframe_end) begin
                $display("%0t: subframe_end expected %b actual %b", $time, e.subframe_end, l);
                errors++;
            end
            if (u[3] !== e.packet_end) begin
                $display("%0t: packet_end expected %b actual %b", $time, e.packet_end, u[3]);
                errors++;
            end
            if (u[4] !== e.sequence_warning) begin
                $display("%0t: sequence_warning expected %b actual %b", $time,
                         e.sequence_warning, u[4]);
                errors++;
            end
            if (u[6:5] !== e.error_code) begin
                $display("%0t: error_code expected %0d actual %0d", $time, e.error_code, u[6:5]);
                errors++;
            end
        endfunction
    endclass

    localparam int StallLimit = 5000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [6:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    science_packet_deframer_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    deframer_scoreboard tags = new();

    // Byte stream still to be sent, and the register values the generator builds against.
    logic [7:0]  stream_q[$];
    logic [31:0] gen_sync;
    logic [15:0] gen_marker;
    logic [7:0]  gen_trig;
    logic [13:0] gen_id;
    int          n_bytes_sent;
    int          n_cfg_writes;

    // Add one byte at the tail of a byte queue.
    function automatic void append_byte(ref logic [7:0] q[$], input logic [7:0] v);
        q = {q, v};
    endfunction

    // Every accepted word in either direction goes to the scoreboard at the
    // rising edge. The watchdog counts edges on which nothing moves at all.
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) tags.note_byte(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                tags.check_word(m_axis_tdata, m_axis_tuser, m_axis_tlast);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= StallLimit) begin
                $display("%0t: watchdog expired, %0d tags still pending", $time,
                         tags.tag_q.size());
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // The receiver switches at random between four stall styles: always ready, coin
    // flips, a fixed duty pattern, and rare stalls.
    int rx_cycle = 0;
    int rx_mode = 0;
    always @(negedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 200 == 0) rx_mode <= $urandom_range(0, 3);
        case (rx_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            2: m_axis_tready <= (rx_cycle % 8) < 5;
            default: m_axis_tready <= ($urandom_range(0, 9) != 0);
        endcase
    end

    task automatic write_reg(t_reg_idx idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        tags.set_reg(idx, val);
        n_cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_config(logic [31:0] sw, logic [15:0] mk, logic [7:0] tl);
        write_reg(REG_SYNC_WORD, sw);
        write_reg(REG_MARKER, mk);
        write_reg(REG_TRIG_LEN, tl);
        gen_sync = sw;
        gen_marker = mk;
        gen_trig = tl;
    endtask

    // Send the queued bytes in bursts of random length with random gaps. Valid
    // stays high across a burst, so it is only ever assigned once per step.
    task automatic send_stream();
        int burst, gap;
        while (stream_q.size() > 0) begin
            burst = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            while (burst > 0 && stream_q.size() > 0) begin
                @(negedge i_clk);
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= stream_q.pop_front();
                @(posedge i_clk);
                while (!s_axis_tready) @(posedge i_clk);
                n_bytes_sent++;
                burst--;
            end
            if (gap > 0) begin
                @(negedge i_clk);
                s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
    endtask

    // Wait until every predicted tag has come out, then let the clock run on so
    // that nothing is left in the output queue before a register write.
    task automatic drain();
        while (tags.tag_q.size() > 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    function automatic logic [7:0] trigger_id();
        logic [7:0] r;
        r = 8'($urandom_range(0, 255));
        return (r & ~TrigMask) | TrigValue;
    endfunction

    function automatic logic [7:0] frontend_id();
        logic [7:0] r;
        r = 8'($urandom_range(0, 255));
        if ((r & TrigMask) == TrigValue) r[2] = ~r[2];
        return r;
    endfunction

    // Append one sub-frame to a body. Length m applies to front-end sub-frames only.
    task automatic add_subframe(ref logic [7:0] body[$], input bit is_trig, input int m);
        int tl;
        append_byte(body, gen_marker[15:8]);
        append_byte(body, gen_marker[7:0]);
        append_byte(body, 8'($urandom_range(0, 255)));
        if (is_trig) begin
            append_byte(body, trigger_id());
            tl = (gen_trig < 2) ? 2 : gen_trig;
            repeat (tl - 2) append_byte(body, 8'($urandom_range(0, 255)));
        end else begin
            append_byte(body, frontend_id());
            append_byte(body, m[15:8]);
            append_byte(body, m[7:0]);
            repeat ((m > 2) ? m - 2 : 0) append_byte(body, 8'($urandom_range(0, 255)));
        end
    endtask

    // Build one packet of the given shape and queue it, sync word first.
    task automatic add_packet(t_pkt_kind kind);
        logic [7:0]  body[$];
        logic [15:0] n;
        int          nsub, pos;
        case (kind)
            PK_EMPTY: ;
            PK_SHORT_LEN: ;
            PK_SYNC_HALF: begin
                add_subframe(body, 0, $urandom_range(2, 6));
                append_byte(body, gen_sync[31:24]);
                append_byte(body, gen_sync[23:16]);
                repeat ($urandom_range(0, 5)) append_byte(body, 8'($urandom_range(0, 255)));
            end
            PK_BAD_MARKER: begin
                if ($urandom_range(0, 1)) add_subframe(body, 0, $urandom_range(2, 5));
                else add_subframe(body, 1, 0);
                append_byte(body, ~gen_marker[15:8]);
                append_byte(body, 8'($urandom_range(0, 255)));
                repeat (4) append_byte(body, 8'($urandom_range(0, 255)));
            end
            PK_FE_TOO_SHORT: begin
                add_subframe(body, 0, $urandom_range(0, 1));
                repeat (3) append_byte(body, 8'($urandom_range(0, 255)));
            end
            PK_FE_MIN: add_subframe(body, 0, 2);
            PK_TRIG_ONLY: add_subframe(body, 1, 0);
            default: begin
                nsub = $urandom_range(1, 4);
                repeat (nsub) begin
                    if ($urandom_range(0, 2) == 0 && gen_trig < 40) add_subframe(body, 1, 0);
                    else add_subframe(body, 0, $urandom_range(2, 12));
                end
            end
        endcase
        if (kind == PK_CUT_BODY && body.size() > 0)
            repeat ($urandom_range(1, 3)) if (body.size() > 0) void'(body.pop_back());
        if (kind == PK_CUT_BODY) begin
            // Give up a few body bytes so the length runs out inside an open field.
            add_subframe(body, 0, $urandom_range(4, 8));
            pos = $urandom_range(1, 3);
            n = 16'(body.size() + 7 - pos);
        end else begin
            n = 16'(body.size() + 7);
        end
        if (kind == PK_SHORT_LEN) n = 16'($urandom_range(0, 6));

        // Packet ids mostly count up, with an occasional jump.
        if ($urandom_range(0, 7) == 0) gen_id = 14'($urandom_range(0, 16383));
        else gen_id = gen_id + 14'd1;

        for (int i = 3; i >= 0; i--) append_byte(stream_q, gen_sync[i*8 +: 8]);
        append_byte(stream_q, {2'($urandom_range(0, 3)), gen_id[13:8]});
        append_byte(stream_q, gen_id[7:0]);
        append_byte(stream_q, n[15:8]);
        append_byte(stream_q, n[7:0]);
        repeat (8) append_byte(stream_q, 8'($urandom_range(0, 255)));
        if (kind == PK_CUT_BODY) repeat (pos) void'(body.pop_back());
        foreach (body[i]) append_byte(stream_q, body[i]);
    endtask

    // A run of random packets, mostly well formed and back to back, with some
    // noise, flipped bytes and broken shapes mixed in.
    task automatic add_random_packets(int nbytes);
        int start, pos;
        t_pkt_kind k;
        start = stream_q.size();
        while (stream_q.size() - start < nbytes) begin
            case ($urandom_range(0, 19))
                0: k = PK_EMPTY;
                1: k = PK_SHORT_LEN;
                2: k = PK_SYNC_HALF;
                3: k = PK_BAD_MARKER;
                4: k = PK_FE_TOO_SHORT;
                5: k = PK_FE_MIN;
                6: k = PK_CUT_BODY;
                7: k = PK_TRIG_ONLY;
                default: k = PK_MIXED;
            endcase
            pos = stream_q.size();
            add_packet(k);
            if ($urandom_range(0, 9) == 0)
                stream_q[$urandom_range(pos, stream_q.size() - 1)] =
                    8'($urandom_range(0, 255));
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 8))
                    append_byte(stream_q, 8'($urandom_range(0, 255)));
        end
        // Close the last packet so its packet end is seen too.
        for (int i = 3; i >= 0; i--) append_byte(stream_q, gen_sync[i*8 +: 8]);
    endtask

    initial begin
        gen_sync = SyncReset;
        gen_marker = MarkerReset;
        gen_trig = TrigReset;
        gen_id = '0;
        n_bytes_sent = 0;
        n_cfg_writes = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part with the reset registers: noise with every bit set and
        // cleared, then one packet of each special shape, among mixed packets.
        append_byte(stream_q, 8'h00);
        append_byte(stream_q, 8'hff);
        add_packet(PK_MIXED);
        add_packet(PK_EMPTY);
        add_packet(PK_TRIG_ONLY);
        add_packet(PK_FE_MIN);
        add_packet(PK_SYNC_HALF);
        add_packet(PK_MIXED);
        add_packet(PK_BAD_MARKER);
        add_packet(PK_SHORT_LEN);
        add_packet(PK_FE_TOO_SHORT);
        add_packet(PK_CUT_BODY);
        add_packet(PK_MIXED);
        for (int i = 3; i >= 0; i--) append_byte(stream_q, gen_sync[i*8 +: 8]);
        send_stream();
        drain();

        // Random phases over several register settings, extremes included.
        // Trigger lengths of zero and one behave as two.
        add_random_packets(150);
        send_stream();
        drain();
        set_config(32'hffff_ffff, 16'h0000, 8'd0);
        add_random_packets(150);
        send_stream();
        drain();
        set_config(32'h0000_0000, 16'hffff, 8'd255);
        add_random_packets(150);
        send_stream();
        drain();
        set_config($urandom, 16'($urandom_range(0, 65535)), 8'd1);
        add_random_packets(150);
        send_stream();
        drain();
        set_config($urandom, 16'($urandom_range(0, 65535)), 8'($urandom_range(2, 20)));
        add_random_packets(150);
        send_stream();
        drain();
        repeat (10) @(posedge i_clk);

        $display("Sent %0d bytes over %0d register writes; checked %0d tagged words.",
                 n_bytes_sent, n_cfg_writes, tags.n_checked);
        $display("Saw %0d packet ends, %0d error words and %0d sequence warnings.",
                 tags.n_pkt_end, tags.n_err_words, tags.n_warn);
        if (tags.errors == 0 && tags.tag_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches, %0d tags never seen", tags.errors, tags.tag_q.size());
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
